// ===== src/bsh_pkg.sv =====
// Package for the byte stream hash block.
// Holds field widths, the command codes and the mixing functions.
// No dependencies.
`default_nettype none

package bsh_pkg;

    localparam int unsigned HashWidth  = 64;
    localparam int unsigned ByteWidth  = 8;
    localparam int unsigned PosWidth   = 2;
    localparam int unsigned MixRounds  = 3;
    localparam int unsigned RoundShl   = 16;
    localparam int unsigned RoundShr   = 31;

    localparam logic [ByteWidth-1:0] FINISH_MARK = 8'h80;
    localparam logic [PosWidth-1:0]  LAST_SLOT   = 2'd3;

    typedef enum logic [0:0] {
        CMD_ABSORB = 1'b0,
        CMD_FINISH = 1'b1
    } bsh_cmd_t;

    typedef logic [HashWidth-1:0] bsh_hash_t;
    typedef logic [ByteWidth-1:0] bsh_byte_t;
    typedef logic [PosWidth-1:0]  bsh_pos_t;

    // Places a byte in its big-endian slot of the 32-bit group:
    // slot 0 lands in bits 31..24, slot 3 in bits 7..0.
    function automatic bsh_hash_t place_byte(bsh_byte_t b, bsh_pos_t pos);
        bsh_hash_t wide;
        bsh_pos_t  inv;
        wide = {{(HashWidth-ByteWidth){1'b0}}, b};
        inv  = LAST_SLOT - pos;
        return wide << {inv, 3'b000};
    endfunction

    // One mixing round: increment, add the state shifted left, xor in the
    // state shifted right, all modulo 2^64.
    function automatic bsh_hash_t mix_round(bsh_hash_t h);
        bsh_hash_t t;
        t = h + bsh_hash_t'(1);
        t = t + (t << RoundShl);
        t = t ^ (t >> RoundShr);
        return t;
    endfunction

    function automatic bsh_hash_t mix_all(bsh_hash_t h);
        bsh_hash_t t;
        t = h;
        for (int r = 0; r < MixRounds; r++)
        begin
            t = mix_round(t);
        end
        return t;
    endfunction

endpackage

`default_nettype wire

// ===== src/bsh_if.sv =====
// Channel interfaces for the byte stream hash block.
// bsh_msg_if carries message words in, bsh_digest_if carries digests out.
// Depends on bsh_pkg.
`default_nettype none

interface bsh_msg_if;
    import bsh_pkg::*;

    logic      valid;
    logic      ready;
    bsh_cmd_t  command;
    bsh_byte_t data_byte;

    modport source (output valid, output command, output data_byte, input ready);
    modport sink   (input valid, input command, input data_byte, output ready);
endinterface

interface bsh_digest_if;
    import bsh_pkg::*;

    logic      valid;
    logic      ready;
    bsh_hash_t digest;

    modport source (output valid, output digest, input ready);
    modport sink   (input valid, input digest, output ready);
endinterface

`default_nettype wire

// ===== src/byte_stream_hash64.sv =====
// Top level of the byte stream hash block: input register, mixing logic,
// running hash state and digest output register.
// Depends on bsh_pkg and the interfaces in bsh_if.sv.
//
//   channel   role   payload                       words
//   msg       sink   command, data_byte            one byte or one finish
//   result    source digest (64 bits)              one per finish
//
// A word is taken every clock while the pipe is not blocked. Each word sits
// in the input register, and the state update, with all three mixing rounds
// on a full group or a finish, is registered from there; a finish word's
// digest goes to the digest output register as it leaves the input register.
// The state feedback through three add-shift-xor rounds sets the rate of one
// word per clock. Reset clears the hash state and slot position to zero. A
// held digest stalls a finish word waiting behind it and the words after it.
`default_nettype none

module byte_stream_hash64 (
    input  wire           clk,
    input  wire           rst_n,
    bsh_msg_if.sink       msg,
    bsh_digest_if.source  result
);
    import bsh_pkg::*;

    logic      stage_valid_reg;
    bsh_cmd_t  stage_cmd_reg;
    bsh_byte_t stage_byte_reg;

    bsh_hash_t hash_reg;
    bsh_hash_t hash_next;
    bsh_pos_t  pos_reg;
    bsh_pos_t  pos_next;

    logic      out_valid_reg;
    logic      out_valid_next;
    bsh_hash_t digest_reg;

    logic      is_finish;
    logic      advance;
    logic      out_free;
    bsh_hash_t added;
    bsh_hash_t mixed;

    assign is_finish = (stage_cmd_reg == CMD_FINISH);
    assign out_free  = !out_valid_reg || result.ready;
    assign advance   = stage_valid_reg && (!is_finish || out_free);
    assign msg.ready = !stage_valid_reg || advance;

    assign result.valid  = out_valid_reg;
    assign result.digest = digest_reg;

    always_comb
    begin
        added = hash_reg + place_byte(is_finish ? FINISH_MARK : stage_byte_reg, pos_reg);
        mixed = mix_all(added);

        hash_next = hash_reg;
        pos_next  = pos_reg;
        if (advance)
        begin
            if (is_finish)
            begin
                hash_next = '0;
                pos_next  = '0;
            end
            else
            begin
                // The fourth byte of a group triggers the mix; the slot wraps.
                hash_next = (pos_reg == LAST_SLOT) ? mixed : added;
                pos_next  = pos_reg + bsh_pos_t'(1);
            end
        end

        out_valid_next = out_valid_reg && !result.ready;
        if (advance && is_finish)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            hash_reg        <= '0;
            pos_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (msg.ready)
            begin
                stage_valid_reg <= msg.valid;
            end
            hash_reg      <= hash_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (msg.valid && msg.ready)
        begin
            stage_cmd_reg  <= msg.command;
            stage_byte_reg <= msg.data_byte;
        end
        if (advance && is_finish)
        begin
            digest_reg <= mixed;
        end
    end

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for byte_stream_hash64: random byte messages and
// finish words go in, and each digest is checked against a local hash model.
// Depends on bsh_pkg, the channel interfaces in bsh_if.sv and the block itself.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bsh_pkg::*;

    localparam int unsigned WORD_TARGET    = 750;
    localparam int unsigned CALM_TAIL      = 80;
    localparam int unsigned HOLDOFF_CYCLES = 250;
    localparam int unsigned HOLDOFF_AFTER  = 12;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned DRAIN_CYCLES   = 8;

    typedef struct packed {
        bsh_cmd_t  cmd;
        bsh_byte_t data;
    } msg_word_t;

    logic clk;
    logic rst_n;

    bsh_msg_if    msg_ch ();
    bsh_digest_if dig_ch ();

    byte_stream_hash64 uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .msg    (msg_ch),
        .result (dig_ch)
    );

    msg_word_t pending_words[$];
    bsh_hash_t expected_digests[$];

    // Running copy of the hash: accumulator and slot of the next byte.
    bsh_hash_t hash_acc;
    bsh_pos_t  next_slot;

    int unsigned total_words;
    int unsigned accepted_words;
    int unsigned digests_seen;
    int unsigned error_count;
    int unsigned send_gap;
    int unsigned stall_left;
    int unsigned hold_left;
    int unsigned quiet_cycles;
    bit          hold_done;
    bit          tx_bursty;
    bit          rx_bursty;

    function automatic bsh_hash_t stir3(bsh_hash_t h);
        bsh_hash_t v;
        v = h;
        for (int r = 0; r < MixRounds; r++)
        begin
            v = v + bsh_hash_t'(1);
            v = v + (v << RoundShl);
            v = v ^ (v >> RoundShr);
        end
        return v;
    endfunction

    // Position 0 lands in bits 31..24, position 3 in bits 7..0.
    function automatic bsh_hash_t slot_value(bsh_byte_t b, bsh_pos_t pos);
        int shift_bits;
        shift_bits = (int'(LAST_SLOT) - int'(pos)) * ByteWidth;
        return bsh_hash_t'(b) << shift_bits;
    endfunction

    function automatic void queue_message(bsh_byte_t body[$], bsh_byte_t finish_data);
        foreach (body[i])
        begin
            pending_words.push_back('{CMD_ABSORB, body[i]});
        end
        pending_words.push_back('{CMD_FINISH, finish_data});
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Message driver: offers queued words and updates the hash on each handshake.
    always @(posedge clk or negedge rst_n)
    begin : msg_driver
        msg_word_t w;
        if (!rst_n)
        begin
            msg_ch.valid     <= 1'b0;
            msg_ch.command   <= CMD_ABSORB;
            msg_ch.data_byte <= '0;
            send_gap = 0;
            hash_acc = '0;
            next_slot = '0;
        end
        else
        begin
            if (msg_ch.valid && msg_ch.ready)
            begin
                accepted_words++;
                if (msg_ch.command == CMD_ABSORB)
                begin
                    hash_acc = hash_acc + slot_value(msg_ch.data_byte, next_slot);
                    next_slot = next_slot + bsh_pos_t'(1);
                    if (next_slot == '0)
                        hash_acc = stir3(hash_acc);
                end
                else
                begin
                    hash_acc = stir3(hash_acc + slot_value(FINISH_MARK, next_slot));
                    expected_digests.push_back(hash_acc);
                    hash_acc = '0;
                    next_slot = '0;
                end
            end
            if ($urandom_range(0, 63) == 0)
                tx_bursty = !tx_bursty;
            if (!msg_ch.valid || msg_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    msg_ch.valid <= 1'b0;
                end
                else if (pending_words.size() == 0)
                begin
                    msg_ch.valid <= 1'b0;
                end
                else if (tx_bursty && pending_words.size() > CALM_TAIL &&
                         $urandom_range(0, 9) == 0)
                begin
                    send_gap = $urandom_range(1, 14) - 1;
                    msg_ch.valid <= 1'b0;
                end
                else
                begin
                    w = pending_words.pop_front();
                    msg_ch.valid     <= 1'b1;
                    msg_ch.command   <= w.cmd;
                    msg_ch.data_byte <= w.data;
                end
            end
        end
    end

    // Digest monitor: checks each digest and throttles ready, with one long
    // hold-off so that a finish word backs up behind a held digest.
    always @(posedge clk or negedge rst_n)
    begin : digest_monitor
        bsh_hash_t want;
        if (!rst_n)
        begin
            dig_ch.ready <= 1'b0;
            stall_left = 0;
            hold_left = 0;
        end
        else
        begin
            if (dig_ch.valid && dig_ch.ready)
            begin
                digests_seen++;
                if (expected_digests.size() == 0)
                begin
                    $display("%0t: unexpected digest: expected none, actual %h",
                             $time, dig_ch.digest);
                    error_count++;
                end
                else
                begin
                    want = expected_digests.pop_front();
                    if (dig_ch.digest !== want)
                    begin
                        $display("%0t: digest mismatch: expected %h, actual %h",
                                 $time, want, dig_ch.digest);
                        error_count++;
                    end
                end
            end
            if ($urandom_range(0, 63) == 0)
                rx_bursty = !rx_bursty;
            if (!hold_done && digests_seen >= HOLDOFF_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLDOFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                dig_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                dig_ch.ready <= 1'b0;
            end
            else if (rx_bursty && pending_words.size() > CALM_TAIL &&
                     $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 14) - 1;
                dig_ch.ready <= 1'b0;
            end
            else
            begin
                dig_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((msg_ch.valid && msg_ch.ready) || (dig_ch.valid && dig_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        bsh_byte_t   body[$];
        int unsigned msg_len;

        rst_n = 1'b0;
        msg_ch.valid = 1'b0;
        msg_ch.command = CMD_ABSORB;
        msg_ch.data_byte = '0;
        dig_ch.ready = 1'b0;
        tx_bursty = 1'b1;
        rx_bursty = 1'b1;
        hold_done = 1'b0;
        error_count = 0;
        digests_seen = 0;
        accepted_words = 0;
        quiet_cycles = 0;

        // Directed part: empty messages back to back (one with a nonzero byte
        // on the finish word), a finish at every slot, a full group, and a
        // message that runs one byte into the second group.
        body = {};
        queue_message(body, 8'h00);
        queue_message(body, 8'hFF);
        body = {8'hFF};
        queue_message(body, 8'h00);
        body = {8'h00, 8'hFF};
        queue_message(body, 8'hA5);
        body = {8'hFF, 8'hFF, 8'hFF};
        queue_message(body, 8'h00);
        body = {8'hAA, 8'h55, 8'h01, 8'h80};
        queue_message(body, 8'hFF);
        body = {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        queue_message(body, 8'h00);

        // Random messages, mostly short with an occasional long one.
        while (pending_words.size() < WORD_TARGET)
        begin
            msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                  : $urandom_range(0, 12);
            body = {};
            repeat (msg_len)
                body.push_back(bsh_byte_t'($urandom));
            queue_message(body, bsh_byte_t'($urandom));
        end
        total_words = pending_words.size();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (accepted_words < total_words)
            @(negedge clk);
        while (expected_digests.size() > 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (expected_digests.size() > 0)
            error_count++;
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== byte_stream_hash64.f =====
src/bsh_pkg.sv
src/bsh_if.sv
src/byte_stream_hash64.sv
tb/sv/testbench.sv
